// ===== hw/rtl/tile_sprite_compositor_core_defines.svh =====
// Assertion helpers for the compositor RTL.
// Both expect clk_i and rst_ni in the scope of use.
`ifndef TILE_SPRITE_COMPOSITOR_CORE_DEFINES_SVH
`define TILE_SPRITE_COMPOSITOR_CORE_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define TSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent in one cycle, consequence in the next.
`define TSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tsc_pkg.sv =====
package tsc_pkg;

  // field widths
  localparam int OP_W       = 2;
  localparam int SIDX_W     = 4;
  localparam int POS_W      = 10;
  localparam int IMG_W      = 6;
  localparam int OFF_W      = 6;
  localparam int COLOR_W    = 16;
  localparam int TPOS_W     = 9;
  localparam int PNUM_W     = 6;
  localparam int CRD_W      = 3;   // tile / sprite coordinate, sizes up to 8
  localparam int DIFF_W     = 12;  // signed pixel minus sprite position
  localparam int IMG_CMP_W  = 9;   // holds IMAGE_COUNT up to 256
  localparam int RAW_AW     = 14;  // image address at the largest image count
  localparam int TDATA_IN_W  = 72;
  localparam int TDATA_OUT_W = 24;

  localparam int IMAGE_WORDS = 64;

  // parameter defaults
  localparam int DEF_SPRITE_COUNT = 16;
  localparam int DEF_TILE_W       = 8;
  localparam int DEF_TILE_H       = 8;
  localparam int DEF_SPRITE_W     = 8;
  localparam int DEF_SPRITE_H     = 8;
  localparam int DEF_IMAGE_COUNT  = 64;

  typedef enum logic [OP_W-1:0] {
    OP_SPRITE = 2'd0,
    OP_PIXEL  = 2'd1,
    OP_RENDER = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HIT,
    ST_READ,
    ST_LOAD
  } state_e;

  typedef enum logic [1:0] {
    SRC_BG,
    SRC_MEM,
    SRC_ZERO
  } src_e;

  typedef struct packed {
    logic wr_sprite;
    logic wr_pixel;
    logic start;
    logic hit_en;
    logic read_en;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_pix;
  } status_t;

endpackage

// ===== hw/rtl/tsc_ctrl.sv =====
`include "tile_sprite_compositor_core_defines.svh"

module tsc_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  input  logic [tsc_pkg::OP_W-1:0]     op_i,
  output logic                         s_tready_o,
  input  tsc_pkg::status_t             status_i,
  output tsc_pkg::cmd_t                cmd_o
);

  tsc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      tsc_pkg::ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          unique case (op_i)
            tsc_pkg::OP_SPRITE: cmd_o.wr_sprite = 1'b1;
            tsc_pkg::OP_PIXEL:  cmd_o.wr_pixel  = 1'b1;
            tsc_pkg::OP_RENDER: begin
              cmd_o.start = 1'b1;
              state_d     = tsc_pkg::ST_HIT;
            end
            default: ;  // unused code, dropped
          endcase
        end
      end
      tsc_pkg::ST_HIT: begin
        cmd_o.hit_en = 1'b1;
        state_d      = tsc_pkg::ST_READ;
      end
      tsc_pkg::ST_READ: begin
        cmd_o.read_en = 1'b1;
        state_d       = tsc_pkg::ST_LOAD;
      end
      tsc_pkg::ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.last_pix ? tsc_pkg::ST_IDLE : tsc_pkg::ST_HIT;
        end
      end
      default: state_d = tsc_pkg::ST_IDLE;
    endcase
  end

  `TSC_ASSERT(a_load_free, cmd_o.load |-> status_i.out_free, "pixel loaded over a held result")
  `TSC_ASSERT_NEXT(a_read_load, state_q == tsc_pkg::ST_READ, state_q == tsc_pkg::ST_LOAD, "read not followed by load")
  `TSC_ASSERT_NEXT(a_last_idle, cmd_o.load && status_i.last_pix, state_q == tsc_pkg::ST_IDLE, "tile did not end on last pixel")
  `TSC_ASSERT(a_write_idle, (cmd_o.wr_sprite || cmd_o.wr_pixel) |-> (state_q == tsc_pkg::ST_IDLE && s_tvalid_i), "write outside idle")

endmodule

// ===== hw/rtl/tsc_datapath.sv =====
module tsc_datapath #(
  parameter int SPRITE_COUNT = tsc_pkg::DEF_SPRITE_COUNT,
  parameter int TILE_W       = tsc_pkg::DEF_TILE_W,
  parameter int TILE_H       = tsc_pkg::DEF_TILE_H,
  parameter int SPRITE_W     = tsc_pkg::DEF_SPRITE_W,
  parameter int SPRITE_H     = tsc_pkg::DEF_SPRITE_H,
  parameter int IMAGE_COUNT  = tsc_pkg::DEF_IMAGE_COUNT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tsc_pkg::cmd_t                 cmd_i,
  output tsc_pkg::status_t              status_o,
  // item fields
  input  logic [tsc_pkg::SIDX_W-1:0]    sprite_index_i,
  input  logic                          sprite_active_i,
  input  logic [tsc_pkg::POS_W-1:0]     sprite_x_i,
  input  logic [tsc_pkg::POS_W-1:0]     sprite_y_i,
  input  logic [tsc_pkg::IMG_W-1:0]     image_index_i,
  input  logic [tsc_pkg::OFF_W-1:0]     pixel_offset_i,
  input  logic [tsc_pkg::COLOR_W-1:0]   pixel_color_i,
  input  logic [tsc_pkg::TPOS_W-1:0]    tile_x_i,
  input  logic [tsc_pkg::TPOS_W-1:0]    tile_y_i,
  // background register
  input  logic                          cfg_we_i,
  input  logic [tsc_pkg::COLOR_W-1:0]   cfg_data_i,
  // result
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [tsc_pkg::COLOR_W-1:0]   out_color_o,
  output logic [tsc_pkg::PNUM_W-1:0]    out_pnum_o,
  output logic                          out_last_o
);

  localparam int POS_W     = tsc_pkg::POS_W;
  localparam int DIFF_W    = tsc_pkg::DIFF_W;
  localparam int CRD_W     = tsc_pkg::CRD_W;
  localparam int OFF_W     = tsc_pkg::OFF_W;
  localparam int IMG_W     = tsc_pkg::IMG_W;
  localparam int COLOR_W   = tsc_pkg::COLOR_W;
  localparam int PNUM_W    = tsc_pkg::PNUM_W;
  localparam int MEM_DEPTH = IMAGE_COUNT * tsc_pkg::IMAGE_WORDS;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int SIW       = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
  localparam int TILE_PIX  = TILE_W * TILE_H;

  // sprite table
  logic                 tbl_act_q [SPRITE_COUNT];
  logic [POS_W-1:0]     tbl_x_q   [SPRITE_COUNT];
  logic [POS_W-1:0]     tbl_y_q   [SPRITE_COUNT];
  logic [IMG_W-1:0]     tbl_img_q [SPRITE_COUNT];

  // render position
  logic [tsc_pkg::TPOS_W-1:0] tile_x_q, tile_y_q;
  logic [CRD_W-1:0]           col_q, row_q;
  logic [PNUM_W-1:0]          pnum_q;
  logic                       last_pix;
  logic [DIFF_W-1:0]          px, py;

  // coverage stage
  logic [SPRITE_COUNT-1:0] cov, hit_q;
  logic [OFF_W-1:0]        offn  [SPRITE_COUNT];
  logic [OFF_W-1:0]        off_q [SPRITE_COUNT];

  // select / read stage
  logic                    sel_hit;
  logic [SIW-1:0]          sel_idx;
  logic [IMG_W-1:0]        sel_img;
  logic                    sel_img_ok;
  logic [tsc_pkg::RAW_AW-1:0] rd_raw, wr_raw;
  logic                    wr_img_ok;
  logic [COLOR_W-1:0]      mem [MEM_DEPTH];
  logic [COLOR_W-1:0]      mem_q;
  tsc_pkg::src_e           src_q;

  logic [COLOR_W-1:0]      bg_q;
  logic [COLOR_W-1:0]      pix_color;
  logic                    out_valid_q;

  assign px = DIFF_W'(tile_x_q) + DIFF_W'(col_q);
  assign py = DIFF_W'(tile_y_q) + DIFF_W'(row_q);

  for (genvar g = 0; g < SPRITE_COUNT; g++) begin : g_spr
    logic signed [DIFF_W-1:0] dx, dy;
    logic                     we;

    assign we = cmd_i.wr_sprite && ({3'b000, sprite_index_i} == 7'(g));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tbl_act_q[g] <= 1'b0;
      end else if (we) begin
        tbl_act_q[g] <= sprite_active_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (we) begin
        tbl_x_q[g]   <= sprite_x_i;
        tbl_y_q[g]   <= sprite_y_i;
        tbl_img_q[g] <= image_index_i;
      end
    end

    assign dx = $signed(px) - $signed({{(DIFF_W-POS_W){tbl_x_q[g][POS_W-1]}}, tbl_x_q[g]});
    assign dy = $signed(py) - $signed({{(DIFF_W-POS_W){tbl_y_q[g][POS_W-1]}}, tbl_y_q[g]});

    assign cov[g] = tbl_act_q[g]
                 && !dx[DIFF_W-1] && (dx[DIFF_W-2:0] < (DIFF_W-1)'(SPRITE_W))
                 && !dy[DIFF_W-1] && (dy[DIFF_W-2:0] < (DIFF_W-1)'(SPRITE_H));

    assign offn[g] = OFF_W'({{(OFF_W-CRD_W){1'b0}}, dy[CRD_W-1:0]} * OFF_W'(SPRITE_W))
                   + {{(OFF_W-CRD_W){1'b0}}, dx[CRD_W-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hit_en) begin
      hit_q <= cov;
      for (int i = 0; i < SPRITE_COUNT; i++) begin
        off_q[i] <= offn[i];
      end
    end
  end

  // highest-numbered covering sprite wins
  always_comb begin
    sel_hit = 1'b0;
    sel_idx = '0;
    for (int i = 0; i < SPRITE_COUNT; i++) begin
      if (hit_q[i]) begin
        sel_hit = 1'b1;
        sel_idx = SIW'(i);
      end
    end
  end

  assign sel_img    = tbl_img_q[sel_idx];
  assign sel_img_ok = {{(tsc_pkg::IMG_CMP_W-IMG_W){1'b0}}, sel_img}
                      < tsc_pkg::IMG_CMP_W'(IMAGE_COUNT);
  assign wr_img_ok  = {{(tsc_pkg::IMG_CMP_W-IMG_W){1'b0}}, image_index_i}
                      < tsc_pkg::IMG_CMP_W'(IMAGE_COUNT);
  assign rd_raw = {{(tsc_pkg::RAW_AW-IMG_W-OFF_W){1'b0}}, sel_img, off_q[sel_idx]};
  assign wr_raw = {{(tsc_pkg::RAW_AW-IMG_W-OFF_W){1'b0}}, image_index_i, pixel_offset_i};

  // image memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_pixel && wr_img_ok) begin
      mem[wr_raw[AW-1:0]] <= pixel_color_i;
    end
    if (cmd_i.read_en) begin
      mem_q <= mem[rd_raw[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_en) begin
      if (!sel_hit) begin
        src_q <= tsc_pkg::SRC_BG;
      end else if (sel_img_ok) begin
        src_q <= tsc_pkg::SRC_MEM;
      end else begin
        src_q <= tsc_pkg::SRC_ZERO;
      end
    end
  end

  always_comb begin
    unique case (src_q)
      tsc_pkg::SRC_BG:  pix_color = bg_q;
      tsc_pkg::SRC_MEM: pix_color = mem_q;
      default:          pix_color = '0;
    endcase
  end

  // tile origin and pixel walk
  assign last_pix = (pnum_q == PNUM_W'(TILE_PIX - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      tile_x_q <= tile_x_i;
      tile_y_q <= tile_y_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pnum_q <= '0;
    end else if (cmd_i.start) begin
      col_q  <= '0;
      row_q  <= '0;
      pnum_q <= '0;
    end else if (cmd_i.load) begin
      pnum_q <= pnum_q + PNUM_W'(1);
      if (col_q == CRD_W'(TILE_W - 1)) begin
        col_q <= '0;
        row_q <= row_q + CRD_W'(1);
      end else begin
        col_q <= col_q + CRD_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q <= '0;
    end else if (cfg_we_i) begin
      bg_q <= cfg_data_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_color_o <= pix_color;
      out_pnum_o  <= pnum_q;
      out_last_o  <= last_pix;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.last_pix = last_pix;

endmodule

// ===== hw/rtl/tile_sprite_compositor_core.sv =====
// Tile sprite compositor. Holds a table of SPRITE_COUNT sprites (active flag,
// signed 10-bit x/y of the upper left corner, image number) and an image
// memory of IMAGE_COUNT images of 64 RGB565 words each. Every input item
// carries its operation in s_axis_tuser: a sprite write or an image pixel
// write is taken while idle and gives no result; a render item walks the
// TILE_W x TILE_H tile at (tile_x, tile_y) in row-major order and returns one
// item per pixel, tlast on the final one. A pixel covered by active sprites
// takes the color of the highest-numbered one from its image, with no
// transparency; a covering sprite whose image lies beyond the memory gives
// color 0; uncovered pixels take the background register. Each pixel passes
// three steps: a coverage compare against every sprite at once, a priority
// pick plus the single-port image memory read, and the load into the output
// register, which waits while the sink stalls. The output register lets the
// walk run one pixel ahead of the sink. No new item is taken until the last
// pixel of a tile is loaded. The sprite table's active flags clear at reset;
// image memory has no clearing pass and must be written before it is shown.
// The background register may only be written while the block is idle.
module tile_sprite_compositor_core #(
  parameter int SPRITE_COUNT = tsc_pkg::DEF_SPRITE_COUNT,
  parameter int TILE_W       = tsc_pkg::DEF_TILE_W,
  parameter int TILE_H       = tsc_pkg::DEF_TILE_H,
  parameter int SPRITE_W     = tsc_pkg::DEF_SPRITE_W,
  parameter int SPRITE_H     = tsc_pkg::DEF_SPRITE_H,
  parameter int IMAGE_COUNT  = tsc_pkg::DEF_IMAGE_COUNT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // sprite_index[3:0], sprite_active[4], sprite_x[14:5], sprite_y[24:15],
  // image_index[30:25], pixel_offset[36:31], pixel_color[52:37],
  // tile_x[61:53], tile_y[70:62], zero pad [71]
  input  logic [tsc_pkg::TDATA_IN_W-1:0]    s_axis_tdata,
  // operation[1:0]
  input  logic [tsc_pkg::OP_W-1:0]          s_axis_tuser,
  // tile pixels
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // color[15:0], pixel_number[21:16], zero pad [23:22]
  output logic [tsc_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast,
  // background color register
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tsc_pkg::COLOR_W-1:0]       cfg_data_i
);

  tsc_pkg::cmd_t    cmd;
  tsc_pkg::status_t status;

  logic [tsc_pkg::COLOR_W-1:0] out_color;
  logic [tsc_pkg::PNUM_W-1:0]  out_pnum;

  // register is always writable
  assign cfg_ready_o = 1'b1;

  tsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .op_i       (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tsc_datapath #(
    .SPRITE_COUNT (SPRITE_COUNT),
    .TILE_W       (TILE_W),
    .TILE_H       (TILE_H),
    .SPRITE_W     (SPRITE_W),
    .SPRITE_H     (SPRITE_H),
    .IMAGE_COUNT  (IMAGE_COUNT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .sprite_index_i  (s_axis_tdata[3:0]),
    .sprite_active_i (s_axis_tdata[4]),
    .sprite_x_i      (s_axis_tdata[14:5]),
    .sprite_y_i      (s_axis_tdata[24:15]),
    .image_index_i   (s_axis_tdata[30:25]),
    .pixel_offset_i  (s_axis_tdata[36:31]),
    .pixel_color_i   (s_axis_tdata[52:37]),
    .tile_x_i        (s_axis_tdata[61:53]),
    .tile_y_i        (s_axis_tdata[70:62]),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_color_o     (out_color),
    .out_pnum_o      (out_pnum),
    .out_last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_pnum, out_color};

endmodule
